// ----- rtl/core/minmax_range_remap_macros.svh -----
// Assertion macros shared by the range remap checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MINMAX_RANGE_REMAP_MACROS_SVH
`define MINMAX_RANGE_REMAP_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define MMR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define MMR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/mmr_pkg.sv -----
// Shared types and constants of the min/max range remap block.
// Depends on nothing; used by every module of the block.
package mmr_pkg;

  // Fixed data widths
  localparam int CHANNEL_BITS  = 16;
  localparam int TARGET_BITS   = 16;
  localparam int PROD_BITS     = CHANNEL_BITS + TARGET_BITS;
  localparam int STEP_CNT_BITS = $clog2(TARGET_BITS);
  localparam int CFG_IDX_BITS  = 2;

  typedef logic [CFG_IDX_BITS-1:0] cfg_index_t;

  // Register map
  localparam cfg_index_t CFG_TARGET_MAX    = 2'd0;
  localparam cfg_index_t CFG_TARGET_MIN    = 2'd1;
  localparam cfg_index_t CFG_INVERT_ENABLE = 2'd2;

  localparam logic [TARGET_BITS-1:0] TARGET_MAX_RST = 16'd62259;
  localparam logic [TARGET_BITS-1:0] TARGET_MIN_RST = 16'd0;

  // Operation codes
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic                    frame_start;
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
  } in_beat_t;

  typedef struct packed {
    logic [TARGET_BITS-1:0] red_out;
    logic [TARGET_BITS-1:0] green_out;
    logic [TARGET_BITS-1:0] blue_out;
    logic                   flat_frame;
  } out_beat_t;

  // Sequencer to lane controls
  typedef struct packed {
    logic load;   // capture and clamp channel value
    logic mul;    // form dividend from distance and span
    logic step;   // one restoring divide step
  } lane_ctrl_t;

endpackage

// ----- rtl/core/mmr_range.sv -----
// Running min/max tracker over the three channels of measure beats.
// Depends on mmr_pkg.
module mmr_range (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             update,
  input  logic                             restart,
  input  logic [mmr_pkg::CHANNEL_BITS-1:0] red,
  input  logic [mmr_pkg::CHANNEL_BITS-1:0] green,
  input  logic [mmr_pkg::CHANNEL_BITS-1:0] blue,
  output logic [mmr_pkg::CHANNEL_BITS-1:0] range_low,
  output logic [mmr_pkg::CHANNEL_BITS-1:0] range_high
);

  logic [mmr_pkg::CHANNEL_BITS-1:0] min_rg;
  logic [mmr_pkg::CHANNEL_BITS-1:0] max_rg;
  logic [mmr_pkg::CHANNEL_BITS-1:0] pix_low;
  logic [mmr_pkg::CHANNEL_BITS-1:0] pix_high;

  // Smallest and largest channel of this pixel
  always_comb begin
    min_rg   = (red < green) ? red : green;
    max_rg   = (red > green) ? red : green;
    pix_low  = (min_rg < blue) ? min_rg : blue;
    pix_high = (max_rg > blue) ? max_rg : blue;
  end

  // Restart on frame start, otherwise widen the range
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= '0;
    end else if (update) begin
      if (restart) begin
        range_low  <= pix_low;
        range_high <= pix_high;
      end else begin
        if (pix_low < range_low)   range_low  <= pix_low;
        if (pix_high > range_high) range_high <= pix_high;
      end
    end
  end

endmodule

// ----- rtl/core/mmr_lane.sv -----
// One channel lane: clamp, distance, multiply by span, restoring divide.
// Depends on mmr_pkg.
module mmr_lane (
  input  logic                             clk,
  input  mmr_pkg::lane_ctrl_t              ctrl,
  input  logic [mmr_pkg::CHANNEL_BITS-1:0] value,
  input  logic [mmr_pkg::CHANNEL_BITS-1:0] range_low,
  input  logic [mmr_pkg::CHANNEL_BITS-1:0] range_high,
  input  logic                             invert,
  input  logic [mmr_pkg::TARGET_BITS-1:0]  span,
  input  logic [mmr_pkg::CHANNEL_BITS-1:0] spread,
  output logic [mmr_pkg::TARGET_BITS-1:0]  quotient
);

  localparam int CB = mmr_pkg::CHANNEL_BITS;
  localparam int TB = mmr_pkg::TARGET_BITS;
  localparam int PB = mmr_pkg::PROD_BITS;

  logic [CB-1:0] clamped;
  logic [CB-1:0] distance_next;
  logic [CB-1:0] distance;
  logic [PB-1:0] product;
  logic [CB-1:0] rem;
  logic [TB-1:0] low_bits;
  logic [CB:0]   trial;
  logic [CB:0]   diff;
  logic          fits;

  // Clamp into the measured range and take the distance from the chosen end
  always_comb begin
    if (value < range_low) begin
      clamped = range_low;
    end else if (value > range_high) begin
      clamped = range_high;
    end else begin
      clamped = value;
    end
    distance_next = invert ? (range_high - clamped) : (clamped - range_low);
  end

  assign product = {{TB{1'b0}}, distance} * {{CB{1'b0}}, span};

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem, low_bits[TB-1]};
  assign diff  = trial - {1'b0, spread};
  assign fits  = (trial >= {1'b0, spread});

  // Upper dividend half stays below the spread, so TB steps give the quotient
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      distance <= distance_next;
    end
    if (ctrl.mul) begin
      rem      <= product[PB-1:TB];
      low_bits <= product[TB-1:0];
      quotient <= '0;
    end else if (ctrl.step) begin
      rem      <= fits ? diff[CB-1:0] : trial[CB-1:0];
      low_bits <= {low_bits[TB-2:0], 1'b0};
      quotient <= {quotient[TB-2:0], fits};
    end
  end

endmodule

// ----- rtl/core/minmax_range_remap.sv -----
// Top level of the min/max range remap: handshakes, registers, sequencer, merge.
// Depends on mmr_pkg, mmr_range and mmr_lane.
//
//  channel  direction  signals                          beat content
//  in       sink       in_valid, in_ready, in_data      operation, frame_start, RGB
//  out      source     out_valid, out_ready, out_data   remapped RGB, flat_frame
//  cfg      sink       cfg_valid, cfg_ready, cfg_index  cfg_data to register index
//
// A measure beat does not stall the input. A convert beat clamps in its accept cycle, then
// passes a multiply state, 16 restoring divide steps per lane and a done state where the
// lanes merge into the output register; the next beat is taken once the result has loaded.
// rst is synchronous: range cleared, registers back to defaults, output empty.
// A full output register holds the lanes in their done state until it drains;
// cfg is always ready.
module minmax_range_remap (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mmr_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mmr_pkg::out_beat_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  mmr_pkg::cfg_index_t           cfg_index,
  input  logic [mmr_pkg::TARGET_BITS-1:0] cfg_data
);

  localparam int CB = mmr_pkg::CHANNEL_BITS;
  localparam int TB = mmr_pkg::TARGET_BITS;
  localparam int SB = mmr_pkg::STEP_CNT_BITS;
  localparam logic [SB-1:0] LAST_STEP = SB'(TB - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [SB-1:0]       step_cnt;
  logic [TB-1:0]       target_max;
  logic [TB-1:0]       target_min;
  logic                invert_enable;
  logic [CB-1:0]       range_low;
  logic [CB-1:0]       range_high;
  logic [CB-1:0]       spread;
  logic [TB-1:0]       span;
  logic                flat;
  logic                accept;
  logic                measure_acc;
  logic                convert_acc;
  logic                load_out;
  logic [TB:0]         target_sum;
  logic [TB-1:0]       midpoint;
  logic [TB-1:0]       quo_red;
  logic [TB-1:0]       quo_green;
  logic [TB-1:0]       quo_blue;
  mmr_pkg::lane_ctrl_t lane_ctrl;
  mmr_pkg::out_beat_t  merged;

  // Input handshake
  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign measure_acc = accept && (in_data.operation == mmr_pkg::OP_MEASURE);
  assign convert_acc = accept && (in_data.operation == mmr_pkg::OP_CONVERT);
  assign load_out    = (state == S_DONE) && (!out_valid || out_ready);

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_max    <= mmr_pkg::TARGET_MAX_RST;
      target_min    <= mmr_pkg::TARGET_MIN_RST;
      invert_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mmr_pkg::CFG_TARGET_MAX:    target_max    <= cfg_data;
        mmr_pkg::CFG_TARGET_MIN:    target_min    <= cfg_data;
        mmr_pkg::CFG_INVERT_ENABLE: invert_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Range tracking on measure beats
  mmr_range u_range (
    .clk        (clk),
    .rst        (rst),
    .update     (measure_acc),
    .restart    (in_data.frame_start),
    .red        (in_data.red_in),
    .green      (in_data.green_in),
    .blue       (in_data.blue_in),
    .range_low  (range_low),
    .range_high (range_high)
  );

  // Capture per-beat divisor, output span and flat flag
  always_ff @(posedge clk) begin
    if (convert_acc) begin
      flat   <= (range_high <= range_low);
      spread <= range_high - range_low;
      span   <= (target_max >= target_min) ? (target_max - target_min) : '0;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (convert_acc) state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (step_cnt == LAST_STEP) state_next = S_DONE;
      S_DONE: if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_MUL) begin
        step_cnt <= '0;
      end else if (state == S_DIV) begin
        step_cnt <= step_cnt + 1'b1;
      end
    end
  end

  assign lane_ctrl.load = convert_acc;
  assign lane_ctrl.mul  = (state == S_MUL);
  assign lane_ctrl.step = (state == S_DIV);

  // Channel lanes
  mmr_lane u_lane_red (
    .clk        (clk),
    .ctrl       (lane_ctrl),
    .value      (in_data.red_in),
    .range_low  (range_low),
    .range_high (range_high),
    .invert     (invert_enable),
    .span       (span),
    .spread     (spread),
    .quotient   (quo_red)
  );

  mmr_lane u_lane_green (
    .clk        (clk),
    .ctrl       (lane_ctrl),
    .value      (in_data.green_in),
    .range_low  (range_low),
    .range_high (range_high),
    .invert     (invert_enable),
    .span       (span),
    .spread     (spread),
    .quotient   (quo_green)
  );

  mmr_lane u_lane_blue (
    .clk        (clk),
    .ctrl       (lane_ctrl),
    .value      (in_data.blue_in),
    .range_low  (range_low),
    .range_high (range_high),
    .invert     (invert_enable),
    .span       (span),
    .spread     (spread),
    .quotient   (quo_blue)
  );

  // Merge lanes: offset by target_min, or midpoint for a flat frame
  assign target_sum = {1'b0, target_max} + {1'b0, target_min};
  assign midpoint   = target_sum[TB:1];

  always_comb begin
    merged.red_out    = flat ? midpoint : (target_min + quo_red);
    merged.green_out  = flat ? midpoint : (target_min + quo_green);
    merged.blue_out   = flat ? midpoint : (target_min + quo_blue);
    merged.flat_frame = flat;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= merged;
    end
  end

endmodule

// ----- rtl/core/mmr_checker.sv -----
// Port-level checks of the range remap block, bound to the top level.
// Depends on mmr_pkg and minmax_range_remap_macros.svh.
`include "minmax_range_remap_macros.svh"

module mmr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input mmr_pkg::in_beat_t               in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input mmr_pkg::out_beat_t              out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input mmr_pkg::cfg_index_t             cfg_index,
  input logic [mmr_pkg::TARGET_BITS-1:0] cfg_data
);

  logic in_beat;
  logic cfg_beat;

  assign in_beat  = in_valid && in_ready;
  assign cfg_beat = cfg_valid && cfg_ready && (cfg_index == mmr_pkg::CFG_TARGET_MAX);

  // Stalled result holds
  `MMR_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  // Convert beat makes the block busy
  `MMR_ASSERT(a_convert_busy, clk, rst, in_beat && (in_data.operation == mmr_pkg::OP_CONVERT) |=> !in_ready, "accepted beat right after a convert")

  // Measure beat never stalls the input
  `MMR_ASSERT(a_measure_free, clk, rst, in_beat && (in_data.operation == mmr_pkg::OP_MEASURE) |=> in_ready, "measure beat stalled the input")

  // New result only appears after a busy cycle
  `MMR_ASSERT(a_result_after_busy, clk, rst, $rose(out_valid) |-> $past(!in_ready), "result appeared without conversion")

  // Reset empties the output and opens the input
  `MMR_ASSERT_ALWAYS(a_reset_state, clk, rst |=> !out_valid && in_ready && (cfg_beat || !cfg_beat), "bad state after reset")

endmodule

bind minmax_range_remap mmr_checker u_checker (.*);
